>>> rtl/core/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants of the lidar sector minimum block.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int RANGE_W     = 16;
    localparam int MIN_W       = 14;
    localparam int CFG_W       = 16;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [MIN_W-1:0] MIN_INIT = MIN_W'(10000);

    typedef enum logic [2:0] {
        REG_ANGLE_START  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_RANGE_FLOOR  = 3'd2,
        REG_RANGE_CEIL   = 3'd3,
        REG_OBST_THRESH  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        SEC_NONE,
        SEC_FRONT,
        SEC_LEFT,
        SEC_RIGHT,
        SEC_BACK
    } t_sector;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               not_finite;
        logic               last_sample;
    } t_in;

    typedef struct packed {
        logic [MIN_W-1:0] front_min_mm;
        logic [MIN_W-1:0] left_min_mm;
        logic [MIN_W-1:0] right_min_mm;
        logic [MIN_W-1:0] back_min_mm;
        logic             obstacle;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] angle_start;
        logic [CFG_W-1:0] angle_step;
        logic [CFG_W-1:0] range_floor_mm;
        logic [CFG_W-1:0] range_ceiling_mm;
        logic [CFG_W-1:0] obstacle_threshold_mm;
    } t_cfg;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        t_sector            sector;
        logic               last;
    } t_work;

endpackage

>>> rtl/core/lidar_sector_minimum.sv
// ----------------------------------------------------------------------------
// lidar_sector_minimum
// Per-sector minimum range over one lidar scan, with an obstacle flag.
// ----------------------------------------------------------------------------
// Takes one range sample per clock cycle while the queue has room. The front
// stage computes the sample angle and sector in the accept cycle and writes a
// four-entry queue; the back stage folds one queued sample per cycle into the
// sector minima, holding a scan's last sample while the result is stalled.
// A scan's last sample passes through the queue into the result register.
// Input ready drops only when the queue fills, when a stalled consumer holds
// the result register. Write configuration only while no scan is in flight.
module lidar_sector_minimum #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lsm_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lsm_pkg::t_out               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsm_pkg::PADDR_W-1:0] paddr,
    input  logic [lsm_pkg::PDATA_W-1:0] pwdata,
    output logic [lsm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    lsm_pkg::t_cfg  cfg;
    lsm_pkg::t_work push_work;
    lsm_pkg::t_work head_work;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    lsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lsm_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_work     (push_work)
    );

    lsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_work  (head_work),
        .o_empty (empty)
    );

    lsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_work      (head_work),
        .o_pop       (pop),
        .i_threshold (cfg.obstacle_threshold_mm),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/lsm_regs.sv
// ----------------------------------------------------------------------------
// lsm_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module lsm_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsm_pkg::PADDR_W-1:0] paddr,
    input  logic [lsm_pkg::PDATA_W-1:0] pwdata,
    output logic [lsm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output lsm_pkg::t_cfg               o_cfg
);

    lsm_pkg::t_cfg    r_cfg;
    lsm_pkg::t_cfg    n_cfg;
    lsm_pkg::t_reg_idx idx;
    logic [lsm_pkg::CFG_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = lsm_pkg::t_reg_idx'(paddr[4:2]);
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                lsm_pkg::REG_ANGLE_START: n_cfg.angle_start = pwdata[lsm_pkg::CFG_W-1:0];
                lsm_pkg::REG_ANGLE_STEP:  n_cfg.angle_step  = pwdata[lsm_pkg::CFG_W-1:0];
                lsm_pkg::REG_RANGE_FLOOR: n_cfg.range_floor_mm = pwdata[lsm_pkg::CFG_W-1:0];
                lsm_pkg::REG_RANGE_CEIL:  n_cfg.range_ceiling_mm = pwdata[lsm_pkg::CFG_W-1:0];
                lsm_pkg::REG_OBST_THRESH: n_cfg.obstacle_threshold_mm =
                                              pwdata[lsm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lsm_pkg::REG_ANGLE_START: rd_val = r_cfg.angle_start;
            lsm_pkg::REG_ANGLE_STEP:  rd_val = r_cfg.angle_step;
            lsm_pkg::REG_RANGE_FLOOR: rd_val = r_cfg.range_floor_mm;
            lsm_pkg::REG_RANGE_CEIL:  rd_val = r_cfg.range_ceiling_mm;
            lsm_pkg::REG_OBST_THRESH: rd_val = r_cfg.obstacle_threshold_mm;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = {{(lsm_pkg::PDATA_W-lsm_pkg::CFG_W){1'b0}}, rd_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start           <= 16'd0;
            r_cfg.angle_step            <= 16'd182;
            r_cfg.range_floor_mm        <= 16'd120;
            r_cfg.range_ceiling_mm      <= 16'd3500;
            r_cfg.obstacle_threshold_mm <= 16'd300;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/core/lsm_front.sv
// ----------------------------------------------------------------------------
// lsm_front
// Accepts samples, tracks the sample angle and classifies each sample into
// a sector with its clamped range.
// ----------------------------------------------------------------------------
module lsm_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsm_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lsm_pkg::t_in   i_in_data,
    input  logic           i_full,
    output logic           o_push,
    output lsm_pkg::t_work o_work
);

    localparam logic [ANGLE_BITS-1:0] FRONT_LIM =
        ANGLE_BITS'((64'd45 << ANGLE_BITS) / 64'd360);
    localparam logic [ANGLE_BITS-1:0] SIDE_LIM  =
        ANGLE_BITS'((64'd125 << ANGLE_BITS) / 64'd360);
    localparam logic [ANGLE_BITS-1:0] BACK_LIM  =
        ANGLE_BITS'((64'd145 << ANGLE_BITS) / 64'd360);

    logic [ANGLE_BITS-1:0] r_offset;
    logic [ANGLE_BITS-1:0] n_offset;
    logic [ANGLE_BITS+lsm_pkg::CFG_W-1:0] start_ext;
    logic [ANGLE_BITS+lsm_pkg::CFG_W-1:0] step_ext;
    logic [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-1:0] mag;
    logic                  neg;
    logic [lsm_pkg::RANGE_W-1:0] range_c;
    logic                  keep;
    lsm_pkg::t_sector      sector;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    assign start_ext = {{ANGLE_BITS{1'b0}}, i_cfg.angle_start};
    assign step_ext  = {{ANGLE_BITS{1'b0}}, i_cfg.angle_step};
    assign angle     = start_ext[ANGLE_BITS-1:0] + r_offset;
    assign neg       = angle[ANGLE_BITS-1];
    assign mag       = neg ? (~angle + 1'b1) : angle;

    always_comb begin
        range_c = i_in_data.range_mm;
        if (range_c != '0 && range_c < i_cfg.range_floor_mm) begin
            range_c = i_cfg.range_floor_mm;
        end
        keep = !i_in_data.not_finite && range_c != '0 && range_c <= i_cfg.range_ceiling_mm;
        if (!keep) begin
            sector = lsm_pkg::SEC_NONE;
        end else if (mag <= FRONT_LIM) begin
            sector = lsm_pkg::SEC_FRONT;
        end else if (mag <= SIDE_LIM) begin
            sector = neg ? lsm_pkg::SEC_RIGHT : lsm_pkg::SEC_LEFT;
        end else if (mag > BACK_LIM) begin
            sector = lsm_pkg::SEC_BACK;
        end else begin
            sector = lsm_pkg::SEC_NONE;
        end
    end

    assign o_work.range_mm = range_c;
    assign o_work.sector   = sector;
    assign o_work.last     = i_in_data.last_sample;

    always_comb begin
        n_offset = r_offset;
        if (o_push) begin
            n_offset = i_in_data.last_sample ? '0 : r_offset + step_ext[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

>>> rtl/core/lsm_queue.sv
// ----------------------------------------------------------------------------
// lsm_queue
// Short first-in first-out queue of classified samples.
// ----------------------------------------------------------------------------
module lsm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsm_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_pop,
    output lsm_pkg::t_work o_work,
    output logic           o_empty
);

    lsm_pkg::t_work r_mem [lsm_pkg::QUEUE_DEPTH];
    logic [lsm_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [lsm_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [lsm_pkg::QCNT_W-1:0] r_count;
    logic [lsm_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [lsm_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [lsm_pkg::QCNT_W-1:0] n_count;

    assign o_full  = r_count == lsm_pkg::QCNT_W'(lsm_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_work  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/core/lsm_back.sv
// ----------------------------------------------------------------------------
// lsm_back
// Folds classified samples into the sector minima and emits the result
// register at the end of each scan.
// ----------------------------------------------------------------------------
module lsm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  lsm_pkg::t_work              i_work,
    output logic                        o_pop,
    input  logic [lsm_pkg::CFG_W-1:0]   i_threshold,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lsm_pkg::t_out               o_out_data
);

    logic [lsm_pkg::MIN_W-1:0] r_front, r_left, r_right, r_back;
    logic [lsm_pkg::MIN_W-1:0] n_front, n_left, n_right, n_back;
    logic [lsm_pkg::MIN_W-1:0] u_front, u_left, u_right, u_back;
    logic                      r_out_valid;
    logic                      n_out_valid;
    lsm_pkg::t_out             r_out_data;
    lsm_pkg::t_out             n_out_data;
    logic                      slot_free;
    logic [lsm_pkg::MIN_W-1:0] r14;
    logic                      lower;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_pop       = !i_empty && (!i_work.last || slot_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign r14         = i_work.range_mm[lsm_pkg::MIN_W-1:0];

    always_comb begin
        u_front = r_front;
        u_left  = r_left;
        u_right = r_right;
        u_back  = r_back;
        lower   = 1'b0;
        case (i_work.sector)
            lsm_pkg::SEC_FRONT: begin
                lower = i_work.range_mm < {2'b00, r_front};
                if (lower) u_front = r14;
            end
            lsm_pkg::SEC_LEFT: begin
                lower = i_work.range_mm < {2'b00, r_left};
                if (lower) u_left = r14;
            end
            lsm_pkg::SEC_RIGHT: begin
                lower = i_work.range_mm < {2'b00, r_right};
                if (lower) u_right = r14;
            end
            lsm_pkg::SEC_BACK: begin
                lower = i_work.range_mm < {2'b00, r_back};
                if (lower) u_back = r14;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_front     = r_front;
        n_left      = r_left;
        n_right     = r_right;
        n_back      = r_back;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_pop) begin
            if (i_work.last) begin
                n_out_data.front_min_mm = u_front;
                n_out_data.left_min_mm  = u_left;
                n_out_data.right_min_mm = u_right;
                n_out_data.back_min_mm  = u_back;
                n_out_data.obstacle     = {2'b00, u_front} < i_threshold;
                n_out_valid = 1'b1;
                n_front = lsm_pkg::MIN_INIT;
                n_left  = lsm_pkg::MIN_INIT;
                n_right = lsm_pkg::MIN_INIT;
                n_back  = lsm_pkg::MIN_INIT;
            end else begin
                n_front = u_front;
                n_left  = u_left;
                n_right = u_right;
                n_back  = u_back;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= lsm_pkg::MIN_INIT;
            r_left      <= lsm_pkg::MIN_INIT;
            r_right     <= lsm_pkg::MIN_INIT;
            r_back      <= lsm_pkg::MIN_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_left      <= n_left;
            r_right     <= n_right;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/lsm_checker.sv
// ----------------------------------------------------------------------------
// lsm_checker
// Port-level checks of the lidar sector minimum block.
// ----------------------------------------------------------------------------
module lsm_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  lsm_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result request dropped or changed while stalled");

    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.front_min_mm <= lsm_pkg::MIN_INIT
                     && o_out_data.left_min_mm  <= lsm_pkg::MIN_INIT
                     && o_out_data.right_min_mm <= lsm_pkg::MIN_INIT
                     && o_out_data.back_min_mm  <= lsm_pkg::MIN_INIT)
        else $error("sector minimum above initial value");

    a_min_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.front_min_mm != '0 && o_out_data.left_min_mm != '0
                     && o_out_data.right_min_mm != '0 && o_out_data.back_min_mm != '0)
        else $error("zero range reached a sector minimum");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result request right after reset");

endmodule

bind lidar_sector_minimum lsm_checker u_lsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lidar sector minimum block.
// ----------------------------------------------------------------------------
// Streams range samples into the block with random gaps on both handshakes.
// An in-bench model folds each accepted sample into its own sector minima and
// queues the scan result that the block should return. Every returned result
// is then checked field by field against that queue.
// Directed scans cover range clamping, skipped samples and the exact sector
// boundaries. Random phases then reprogram every register before their scans,
// all-zero and all-ones settings among them. One phase holds the result side
// off long enough that the block must stall its input.
// ----------------------------------------------------------------------------
module tb;
    import lsm_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int REG_BYTES        = 4;
    localparam int REG_UNUSED_FIRST = 5;
    localparam int REG_SLOTS        = 8;
    localparam int MAX_IDLE         = 17;
    localparam int DRAIN_CYCLES     = 10;
    localparam int STALL_CYCLES     = 400;
    localparam int QUIET_LIMIT      = 3000;
    localparam int PHASES           = 10;
    localparam int PRESSURE_PHASE   = 4;
    localparam int PHASE_SAMPLES    = 125;
    localparam int PRESSURE_SAMPLES = 60;
    localparam int MAX_SCAN         = 60;
    localparam int MAX_REPORTS      = 10;

    localparam int unsigned TURN      = 1 << CFG_W;
    localparam int unsigned FRONT_LIM = 45 * TURN;
    localparam int unsigned SIDE_LIM  = 125 * TURN;
    localparam int unsigned BACK_LIM  = 145 * TURN;

    typedef struct {
        t_in         sample;
        int unsigned gap;
    } t_sample_req;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    t_in                in_data    = '0;
    logic               out_valid;
    logic               out_ready;
    t_out               out_data;
    logic               out_rdy_q  = 1'b1;
    logic               sink_stall = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    t_sample_req sample_q[$];
    t_out        minima_q[$];

    t_cfg             cfg;
    logic [MIN_W-1:0] scan_front;
    logic [MIN_W-1:0] scan_left;
    logic [MIN_W-1:0] scan_right;
    logic [MIN_W-1:0] scan_back;
    logic [CFG_W-1:0] scan_offset;

    int unsigned src_wait     = 0;
    int unsigned sink_wait    = 0;
    int unsigned sink_gap_max = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_asked  = 0;
    int unsigned stall_served = 0;
    int unsigned quiet        = 0;

    int unsigned samples_taken      = 0;
    int unsigned scans_seen         = 0;
    int unsigned reg_writes         = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned mismatches         = 0;

    assign out_ready = out_rdy_q && !sink_stall;

    always #CLK_HALF i_clk = ~i_clk;

    lidar_sector_minimum dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    function automatic void restart_scan();
        scan_front  = MIN_INIT;
        scan_left   = MIN_INIT;
        scan_right  = MIN_INIT;
        scan_back   = MIN_INIT;
        scan_offset = '0;
    endfunction

    function automatic bit fold_sample(input t_in s, output t_out res);
        logic [CFG_W-1:0]   ang;
        logic [CFG_W:0]     mag;
        int unsigned        deg;
        logic [RANGE_W-1:0] r;
        ang = cfg.angle_start + scan_offset;
        mag = {1'b0, ang};
        if (ang[CFG_W-1]) begin
            mag = TURN - mag;
        end
        deg = int'(mag) * 360;
        res = '0;
        r   = s.range_mm;
        if (!s.not_finite) begin
            if (r != 0 && r < cfg.range_floor_mm) begin
                r = cfg.range_floor_mm;
            end
            if (r != 0 && r <= cfg.range_ceiling_mm) begin
                if (deg <= FRONT_LIM) begin
                    if (r < scan_front) scan_front = r[MIN_W-1:0];
                end else if (deg <= SIDE_LIM) begin
                    if (ang[CFG_W-1]) begin
                        if (r < scan_right) scan_right = r[MIN_W-1:0];
                    end else begin
                        if (r < scan_left) scan_left = r[MIN_W-1:0];
                    end
                end else if (deg > BACK_LIM) begin
                    if (r < scan_back) scan_back = r[MIN_W-1:0];
                end
            end
        end
        scan_offset = scan_offset + cfg.angle_step;
        if (!s.last_sample) return 1'b0;
        res.front_min_mm = scan_front;
        res.left_min_mm  = scan_left;
        res.right_min_mm = scan_right;
        res.back_min_mm  = scan_back;
        res.obstacle     = (scan_front < cfg.obstacle_threshold_mm);
        restart_scan();
        return 1'b1;
    endfunction

    function automatic void flag_field(string field, int unsigned want, int unsigned got);
        if (want == got) return;
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch in scan %0d, %s: expected %0d, got %0d",
                     scans_seen, field, want, got);
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] near(logic [CFG_W-1:0] v);
        int x;
        x = int'(v) + int'($urandom_range(0, 4)) - 2;
        if (x < 0) x = 0;
        if (x > 65535) x = 65535;
        return RANGE_W'(x);
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 7))
            0: return RANGE_W'($urandom);
            1: return '0;
            2: return RANGE_W'($urandom_range(0, 600));
            3: return near(cfg.range_floor_mm);
            4: return near(cfg.range_ceiling_mm);
            5: return near(cfg.obstacle_threshold_mm);
            default: return RANGE_W'($urandom_range(0, 12000));
        endcase
    endfunction

    task automatic push_sample(input logic [RANGE_W-1:0] range_mm, input bit bad,
                               input bit last, input int unsigned gap_max);
        t_sample_req req;
        req.sample.range_mm    = range_mm;
        req.sample.not_finite  = bad;
        req.sample.last_sample = last;
        req.gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        sample_q.push_back(req);
    endtask

    task automatic queue_scan(input int len, input int unsigned gap_max);
        for (int k = 0; k < len; k++) begin
            push_sample(pick_range(), $urandom_range(0, 9) == 0, k == len - 1, gap_max);
        end
    endtask

    task automatic reg_write(input int unsigned idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * REG_BYTES);
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            REG_ANGLE_START: cfg.angle_start           = val;
            REG_ANGLE_STEP:  cfg.angle_step            = val;
            REG_RANGE_FLOOR: cfg.range_floor_mm        = val;
            REG_RANGE_CEIL:  cfg.range_ceiling_mm      = val;
            REG_OBST_THRESH: cfg.obstacle_threshold_mm = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || minima_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive
        t_out        res;
        t_sample_req nxt;
        bit          taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            src_wait <= 0;
        end else begin
            taken = in_valid && in_ready;
            if (taken) begin
                samples_taken++;
                if (fold_sample(in_data, res)) minima_q.push_back(res);
            end
            if (in_valid && !in_ready) input_stall_cycles++;
            if (!in_valid || taken) begin
                if (sample_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (src_wait < sample_q[0].gap) begin
                    src_wait <= src_wait + 1;
                    in_valid <= 1'b0;
                end else begin
                    nxt = sample_q.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= nxt.sample;
                    src_wait <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : collect
        t_out        want;
        int unsigned w;
        if (!i_rst_n) begin
            out_rdy_q <= 1'b1;
            sink_wait <= 0;
        end else if (out_valid && out_ready) begin
            scans_seen++;
            if (minima_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("scan result at %0t with no scan pending", $time);
                end
            end else begin
                want = minima_q.pop_front();
                flag_field("front_min_mm", want.front_min_mm, out_data.front_min_mm);
                flag_field("left_min_mm", want.left_min_mm, out_data.left_min_mm);
                flag_field("right_min_mm", want.right_min_mm, out_data.right_min_mm);
                flag_field("back_min_mm", want.back_min_mm, out_data.back_min_mm);
                flag_field("obstacle", want.obstacle, out_data.obstacle);
            end
            w = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
            sink_wait <= w;
            out_rdy_q <= (w == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            out_rdy_q <= (sink_wait == 1);
        end
    end

    // hold the result side off for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left   <= 0;
            sink_stall   <= 1'b0;
            stall_served <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            sink_stall <= (stall_left != 1);
        end else if (stall_served != stall_asked) begin
            stall_left   <= STALL_CYCLES;
            sink_stall   <= 1'b1;
            stall_served <= stall_asked;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("no request moved for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] probe_angles [12];
        t_cfg             next_cfg;
        int unsigned      src_gap;
        int               queued;
        int               len;
        cfg.angle_start           = '0;
        cfg.angle_step            = 16'd182;
        cfg.range_floor_mm        = 16'd120;
        cfg.range_ceiling_mm      = 16'd3500;
        cfg.obstacle_threshold_mm = 16'd300;
        restart_scan();
        probe_angles = '{16'd8192, 16'd8193, 16'd22755, 16'd22756, 16'd26396, 16'd26397,
                         16'd32768, 16'd57344, 16'd57343, 16'd42781, 16'd42780, 16'd39139};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_gap_max = MAX_IDLE;

        // unmapped slots must leave the settings alone
        for (int idx = REG_UNUSED_FIRST; idx < REG_SLOTS; idx++) begin
            reg_write(idx, CFG_W'($urandom));
        end

        push_sample(16'd0, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'd1, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'hFFFF, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'd119, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'd3500, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'd3501, 1'b0, 1'b0, MAX_IDLE);
        push_sample(16'd150, 1'b1, 1'b0, MAX_IDLE);
        push_sample(16'd200, 1'b1, 1'b1, MAX_IDLE);
        push_sample(16'd0, 1'b0, 1'b1, MAX_IDLE);
        wait_drained();

        // pin every sample to one angle and walk the sector edges
        reg_write(REG_ANGLE_STEP, '0);
        reg_write(REG_OBST_THRESH, 16'd1000);
        for (int k = 0; k < 12; k++) begin
            reg_write(REG_ANGLE_START, probe_angles[k]);
            push_sample(RANGE_W'(200 + 97 * k), 1'b0, 1'b1, MAX_IDLE);
            wait_drained();
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: next_cfg = '0;
                1: next_cfg = '1;
                default: begin
                    next_cfg.angle_start           = pick_setting(0, 65535);
                    next_cfg.angle_step            = pick_setting(64, 4096);
                    next_cfg.range_floor_mm        = pick_setting(0, 400);
                    next_cfg.range_ceiling_mm      = pick_setting(800, 12000);
                    next_cfg.obstacle_threshold_mm = pick_setting(100, 3000);
                end
            endcase
            reg_write(REG_ANGLE_START, next_cfg.angle_start);
            reg_write(REG_ANGLE_STEP, next_cfg.angle_step);
            reg_write(REG_RANGE_FLOOR, next_cfg.range_floor_mm);
            reg_write(REG_RANGE_CEIL, next_cfg.range_ceiling_mm);
            reg_write(REG_OBST_THRESH, next_cfg.obstacle_threshold_mm);

            queued = 0;
            if (p == PRESSURE_PHASE) begin
                sink_gap_max = 0;
                stall_asked <= stall_asked + 1;
                while (queued < PRESSURE_SAMPLES) begin
                    len = $urandom_range(1, 3);
                    queue_scan(len, 0);
                    queued += len;
                end
            end else begin
                src_gap      = (p % 3 == 0) ? 0 : MAX_IDLE;
                sink_gap_max = (p % 4 == 1) ? 0 : MAX_IDLE;
                while (queued < PHASE_SAMPLES) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(1, MAX_SCAN);
                    queue_scan(len, src_gap);
                    queued += len;
                end
            end
            wait_drained();
        end

        if (minima_q.size() != 0) begin
            mismatches += minima_q.size();
            $display("%0d scan results never arrived", minima_q.size());
        end
        $display("%0d samples in %0d scans over %0d register writes, input held %0d cycles",
                 samples_taken, scans_seen, reg_writes, input_stall_cycles);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/lsm_pkg.sv
rtl/core/lsm_regs.sv
rtl/core/lsm_front.sv
rtl/core/lsm_queue.sv
rtl/core/lsm_back.sv
rtl/core/lidar_sector_minimum.sv
rtl/core/lsm_checker.sv
tb/tb.sv
